>>> sv/assert_macros.svh
// Assertion helpers, clocked on clk with rst_n low masking the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/plcl_pkg.sv
package plcl_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int DATA_W = 16;
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 18;
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int REM_W  = DIFF_W;
  localparam int BIT_W  = $clog2(NUM_W);
  localparam int SUM_W  = NUM_W + 2;

  localparam logic [DATA_W-1:0] ONE_Q15 = 16'h8000;
  localparam logic signed [SUM_W-1:0] OUT_MAX = 37'sd131071;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -37'sd131072;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_DECODE   = 4'd1;
  localparam step_t S_CHECK    = 4'd2;
  localparam step_t S_SCAN     = 4'd3;
  localparam step_t S_DIFF     = 4'd4;
  localparam step_t S_MUL      = 4'd5;
  localparam step_t S_DIV_INIT = 4'd6;
  localparam step_t S_DIV      = 4'd7;
  localparam step_t S_RESULT   = 4'd8;
  localparam step_t S_EQUAL    = 4'd9;
  localparam step_t S_EMPTY    = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TABLE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_DIFF,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_RESULT,
    OP_EQUAL,
    OP_EMPTY
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_REQ,
    JC_NOT_QUERY,
    JC_EMPTY,
    JC_SCAN_MORE,
    JC_EQUAL,
    JC_DIV_MORE
  } jc_t;

  typedef struct packed {
    logic  in_rdy;
    logic  hold_out;
    op_t   op;
    jc_t   jc;
    step_t tgt;
  } ctl_t;

  // microprogram
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '{in_rdy: 1'b0, hold_out: 1'b0, op: OP_NONE, jc: JC_NEXT, tgt: S_WAIT};
    case (s)
      S_WAIT: begin
        c.in_rdy = 1'b1;
        c.op     = OP_LATCH;
        c.jc     = JC_NO_REQ;
        c.tgt    = S_WAIT;
      end
      S_DECODE: begin
        c.op  = OP_TABLE;
        c.jc  = JC_NOT_QUERY;
        c.tgt = S_WAIT;
      end
      S_CHECK: begin
        c.op  = OP_SCAN_INIT;
        c.jc  = JC_EMPTY;
        c.tgt = S_EMPTY;
      end
      S_SCAN: begin
        c.op  = OP_SCAN;
        c.jc  = JC_SCAN_MORE;
        c.tgt = S_SCAN;
      end
      S_DIFF: begin
        c.op  = OP_DIFF;
        c.jc  = JC_EQUAL;
        c.tgt = S_EQUAL;
      end
      S_MUL: begin
        c.op = OP_MUL;
      end
      S_DIV_INIT: begin
        c.op = OP_DIV_INIT;
      end
      S_DIV: begin
        c.op  = OP_DIV;
        c.jc  = JC_DIV_MORE;
        c.tgt = S_DIV;
      end
      S_RESULT: begin
        c.hold_out = 1'b1;
        c.op       = OP_RESULT;
        c.jc       = JC_ALWAYS;
      end
      S_EQUAL: begin
        c.hold_out = 1'b1;
        c.op       = OP_EQUAL;
        c.jc       = JC_ALWAYS;
      end
      S_EMPTY: begin
        c.hold_out = 1'b1;
        c.op       = OP_EMPTY;
        c.jc       = JC_ALWAYS;
      end
      default: begin
        c.jc = JC_ALWAYS;
      end
    endcase
    return c;
  endfunction

endpackage

>>> sv/plcl_if.sv
interface plcl_in_if;
  logic                           valid;
  logic                           ready;
  logic [plcl_pkg::ACT_W-1:0]     action;
  logic [plcl_pkg::DATA_W-1:0]    point_x_in;
  logic [plcl_pkg::DATA_W-1:0]    point_y_in;

  modport source (output valid, action, point_x_in, point_y_in, input ready);
  modport sink   (input valid, action, point_x_in, point_y_in, output ready);
endinterface

interface plcl_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [plcl_pkg::VAL_W-1:0] curve_value;
  logic                           table_empty;
  logic                           saturated;

  modport source (output valid, curve_value, table_empty, saturated, input ready);
  modport sink   (input valid, curve_value, table_empty, saturated, output ready);
endinterface

>>> sv/piecewise_linear_curve_lookup.sv
// Channel   Dir  Payload                                  Request taken when
// in_chan   in   action, point_x_in, point_y_in           valid && ready
// out_chan  out  curve_value, table_empty, saturated      valid && ready
//
// Clear and append act in the decode step. A query scans the N stored points
// (not on an empty table) and skips the divider when the bracket x values
// match; the single read port scans one point a cycle, then a restoring divider.
// rst_n is synchronous; it empties the table and drops out_chan.valid.
// A finished result sits in the output register; the sequencer holds only if
// the next result is ready while that one is still untaken.
`include "assert_macros.svh"

module piecewise_linear_curve_lookup #(
  parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  plcl_in_if.sink           in_chan,
  plcl_out_if.source        out_chan
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int DW    = plcl_pkg::DATA_W;
  localparam int ENT_W = 2 * DW;

  // sequencer
  plcl_pkg::step_t step_r, step_nxt;
  plcl_pkg::ctl_t  ctl;
  logic            in_acc;
  logic            out_busy;
  logic            stall;
  logic            take;

  // point store
  logic [ENT_W-1:0] pts_mem [MAX_POINTS];
  logic [ENT_W-1:0] rd_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [DW-1:0]    rd_x, rd_y;

  // datapath
  logic [plcl_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [DW-1:0]    q_r, q_nxt, py_r, py_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, i_r, i_nxt;
  logic [DW-1:0]    xl_r, xl_nxt, yl_r, yl_nxt, xg_r, xg_nxt, yg_r, yg_nxt;
  logic             fnd_r, fnd_nxt;
  logic signed [plcl_pkg::DIFF_W-1:0] d_r, d_nxt, dy_r, dy_nxt, den_r, den_nxt;
  logic signed [plcl_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic             neg_r, neg_nxt;
  logic [plcl_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [plcl_pkg::REM_W-1:0] dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [plcl_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic [plcl_pkg::PROD_W-1:0] n_abs;
  logic [plcl_pkg::DIFF_W-1:0] d_abs;
  logic [plcl_pkg::REM_W:0]    trial;
  logic signed [plcl_pkg::SUM_W-1:0] qs, sum;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic signed [plcl_pkg::VAL_W-1:0] val_r, val_nxt;
  logic             empty_r, empty_nxt, sat_r, sat_nxt;

  assign ctl      = plcl_pkg::ucode(step_r);
  assign in_acc   = in_chan.valid && ctl.in_rdy;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign stall    = ctl.hold_out && out_busy;

  assign in_chan.ready        = ctl.in_rdy;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.curve_value = val_r;
  assign out_chan.table_empty = empty_r;
  assign out_chan.saturated   = sat_r;

  assign rd_x = rd_r[ENT_W-1:DW];
  assign rd_y = rd_r[DW-1:0];

  always_comb begin
    case (ctl.jc)
      plcl_pkg::JC_NEXT:      take = 1'b0;
      plcl_pkg::JC_ALWAYS:    take = 1'b1;
      plcl_pkg::JC_NO_REQ:    take = !in_acc;
      plcl_pkg::JC_NOT_QUERY: take = (act_r != plcl_pkg::ACT_QUERY);
      plcl_pkg::JC_EMPTY:     take = (cnt_r == '0);
      plcl_pkg::JC_SCAN_MORE: take = (i_r != cnt_r);
      plcl_pkg::JC_EQUAL:     take = (xg_r == xl_r);
      plcl_pkg::JC_DIV_MORE:  take = (bit_r != '0);
      default:                take = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ctl.tgt;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_comb begin
    act_nxt  = act_r;
    q_nxt    = q_r;
    py_nxt   = py_r;
    cnt_nxt  = cnt_r;
    i_nxt    = i_r;
    xl_nxt   = xl_r;
    yl_nxt   = yl_r;
    xg_nxt   = xg_r;
    yg_nxt   = yg_r;
    fnd_nxt  = fnd_r;
    d_nxt    = d_r;
    dy_nxt   = dy_r;
    den_nxt  = den_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    val_nxt  = val_r;
    empty_nxt = empty_r;
    sat_nxt  = sat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    wr_addr  = cnt_r[IDX_W-1:0];
    rd_addr  = i_r[IDX_W-1:0];
    n_abs    = prod_r[plcl_pkg::PROD_W-1] ? $unsigned(-prod_r) : $unsigned(prod_r);
    d_abs    = den_r[plcl_pkg::DIFF_W-1] ? $unsigned(-den_r) : $unsigned(den_r);
    trial    = {rem_r, num_r[plcl_pkg::NUM_W-1]};
    qs       = $signed({2'b00, num_r});
    sum      = neg_r ? ($signed({{(plcl_pkg::SUM_W-DW){1'b0}}, yl_r}) - qs)
                     : ($signed({{(plcl_pkg::SUM_W-DW){1'b0}}, yl_r}) + qs);
    if (!stall) begin
      case (ctl.op)
        plcl_pkg::OP_LATCH: begin
          if (in_acc) begin
            act_nxt = in_chan.action;
            q_nxt   = in_chan.point_x_in;
            py_nxt  = in_chan.point_y_in;
          end
        end
        plcl_pkg::OP_TABLE: begin
          if (act_r == plcl_pkg::ACT_CLEAR) begin
            cnt_nxt = '0;
          end else if (act_r == plcl_pkg::ACT_APPEND &&
                       cnt_r < CNT_W'(MAX_POINTS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        plcl_pkg::OP_SCAN_INIT: begin
          mem_re  = 1'b1;
          rd_addr = '0;
          i_nxt   = CNT_W'(1);
          xl_nxt  = plcl_pkg::ONE_Q15;
          yl_nxt  = plcl_pkg::ONE_Q15;
          xg_nxt  = '0;
          yg_nxt  = '0;
          fnd_nxt = 1'b0;
        end
        plcl_pkg::OP_SCAN: begin
          // rd_r holds entry i_r - 1
          if (rd_x <= q_r) begin
            xl_nxt = rd_x;
            yl_nxt = rd_y;
          end
          if (!fnd_r && rd_x >= q_r) begin
            xg_nxt  = rd_x;
            yg_nxt  = rd_y;
            fnd_nxt = 1'b1;
          end
          if (i_r != cnt_r) begin
            mem_re = 1'b1;
            i_nxt  = i_r + 1'b1;
          end
        end
        plcl_pkg::OP_DIFF: begin
          d_nxt   = $signed({1'b0, q_r})  - $signed({1'b0, xl_r});
          dy_nxt  = $signed({1'b0, yg_r}) - $signed({1'b0, yl_r});
          den_nxt = $signed({1'b0, xg_r}) - $signed({1'b0, xl_r});
        end
        plcl_pkg::OP_MUL: begin
          prod_nxt = d_r * dy_r;
        end
        plcl_pkg::OP_DIV_INIT: begin
          // round half away: (2|p| + |den|) / (2|den|)
          neg_nxt = prod_r[plcl_pkg::PROD_W-1] ^ den_r[plcl_pkg::DIFF_W-1];
          num_nxt = {n_abs, 1'b0} + {{(plcl_pkg::NUM_W-plcl_pkg::DIFF_W){1'b0}}, d_abs};
          dvs_nxt = {d_abs[plcl_pkg::DIFF_W-2:0], 1'b0};
          rem_nxt = '0;
          bit_nxt = plcl_pkg::BIT_W'(plcl_pkg::NUM_W - 1);
        end
        plcl_pkg::OP_DIV: begin
          if (trial >= {1'b0, dvs_r}) begin
            rem_nxt = plcl_pkg::REM_W'(trial - {1'b0, dvs_r});
            num_nxt = {num_r[plcl_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[plcl_pkg::REM_W-1:0];
            num_nxt = {num_r[plcl_pkg::NUM_W-2:0], 1'b0};
          end
          bit_nxt = bit_r - 1'b1;
        end
        plcl_pkg::OP_RESULT: begin
          out_valid_nxt = 1'b1;
          empty_nxt     = 1'b0;
          if (sum > plcl_pkg::OUT_MAX) begin
            val_nxt = plcl_pkg::OUT_MAX[plcl_pkg::VAL_W-1:0];
            sat_nxt = 1'b1;
          end else if (sum < plcl_pkg::OUT_MIN) begin
            val_nxt = plcl_pkg::OUT_MIN[plcl_pkg::VAL_W-1:0];
            sat_nxt = 1'b1;
          end else begin
            val_nxt = sum[plcl_pkg::VAL_W-1:0];
            sat_nxt = 1'b0;
          end
        end
        plcl_pkg::OP_EQUAL: begin
          out_valid_nxt = 1'b1;
          empty_nxt     = 1'b0;
          sat_nxt       = 1'b0;
          val_nxt       = $signed({{(plcl_pkg::VAL_W-DW){1'b0}}, yg_r});
        end
        plcl_pkg::OP_EMPTY: begin
          out_valid_nxt = 1'b1;
          empty_nxt     = 1'b1;
          sat_nxt       = 1'b0;
          val_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pts_mem[wr_addr] <= {q_r, py_r};
    end
    if (mem_re) begin
      rd_r <= pts_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= plcl_pkg::S_WAIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    q_r     <= q_nxt;
    py_r    <= py_nxt;
    i_r     <= i_nxt;
    xl_r    <= xl_nxt;
    yl_r    <= yl_nxt;
    xg_r    <= xg_nxt;
    yg_r    <= yg_nxt;
    fnd_r   <= fnd_nxt;
    d_r     <= d_nxt;
    dy_r    <= dy_nxt;
    den_r   <= den_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    num_r   <= num_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    val_r   <= val_nxt;
    empty_r <= empty_nxt;
    sat_r   <= sat_nxt;
  end

  `ASSERT_IMPL(a_rise_from_result, $rose(out_valid_r),
               $past(step_r) == plcl_pkg::S_RESULT || $past(step_r) == plcl_pkg::S_EQUAL ||
               $past(step_r) == plcl_pkg::S_EMPTY, "result without result step")
  `ASSERT_NEXT(a_accept_decodes, step_r == plcl_pkg::S_WAIT && in_chan.valid,
               step_r == plcl_pkg::S_DECODE, "accepted request not decoded")
  `ASSERT_IMPL(a_empty_zero, out_valid_r && empty_r, val_r == '0 && !sat_r,
               "empty result carries value")
  `ASSERT_NEXT(a_append_count, step_r == plcl_pkg::S_DECODE &&
               act_r == plcl_pkg::ACT_APPEND && cnt_r < CNT_W'(MAX_POINTS),
               cnt_r == CNT_W'($past(cnt_r) + 1'b1), "append did not grow table")

endmodule
